### src/lrd_pkg.sv
// Package for the log record deframer: request/result types, constants, CRC helper.
package lrd_pkg;

  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES32   = 32'hFFFF_FFFF;
  localparam logic [31:0] HEADER_BYTES = 32'd29;

  typedef enum logic [1:0] {
    PH_SIZE = 2'd0,
    PH_BODY = 2'd1,
    PH_CRC  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_RECORD  = 2'd1,
    KIND_STOP    = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CAUSE_CLEAN     = 3'd0,
    CAUSE_SHORT     = 3'd1,
    CAUSE_TRUNCATED = 3'd2,
    CAUSE_CRC       = 3'd3,
    CAUSE_TOO_LONG  = 3'd4
  } cause_t;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_END  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] sequence_res;
    logic [63:0] timestamp;
    logic [63:0] player_id;
    logic [7:0]  operation;
    logic [31:0] data_size;
    logic [2:0]  stop_cause;
    logic [63:0] next_sequence;
    logic [31:0] record_count;
    logic        last;
  } out_res_t;

  // Reflected CRC-32, one byte.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

### src/log_record_deframer_crc32_check_unit.sv
// Log record deframer: size/body/CRC frame parser with CRC-32 check and verdicts.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_valid / in_stall   | in_req  (command, data_byte)
//   out_    | out | out_valid / out_stall | out_res (kind ... last)
//
// One request per cycle while in_stall is low; each result is registered in out_r,
// or in the skid while out_ stalls. The byte-wise CRC and field capture logic
// feeds that single register stage. A two-entry output (result register plus skid)
// keeps input flowing while one result waits; in_stall rises only when both hold.
// rst_n is synchronous; after reset the block is waiting for a size field.
module log_record_deframer_crc32_check_unit
  import lrd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_res
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] frame_size_r, frame_size_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] check_r, check_nxt;
  logic [63:0] hdr_seq_r, hdr_seq_nxt;
  logic [63:0] hdr_ts_r, hdr_ts_nxt;
  logic [63:0] hdr_player_r, hdr_player_nxt;
  logic [7:0]  hdr_op_r, hdr_op_nxt;
  logic [31:0] hdr_len_r, hdr_len_nxt;
  logic [63:0] highest_r, highest_nxt;
  logic [31:0] count_r, count_nxt;
  logic        halted_r, halted_nxt;

  logic        out_valid_r, skid_valid_r;
  out_res_t    out_r, skid_r;

  logic        accept;
  logic        res_valid;
  out_res_t    res;

  logic [7:0]  b;
  logic [31:0] pos_inc;
  logic [31:0] body_len;
  logic [31:0] fs_new;
  logic [31:0] check_new;
  logic [32:0] hdr_end;
  logic [32:0] payload_end;
  logic        is_payload;
  logic        frame_ends;
  logic        size_done;
  logic        crc_bad;
  logic        too_long;

  assign in_stall  = skid_valid_r;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  assign b           = in_req.data_byte;
  assign pos_inc     = pos_r + 32'd1;
  assign body_len    = frame_size_r - 32'd4;
  assign fs_new      = frame_size_r | ({24'd0, b} << {pos_r[1:0], 3'b000});
  assign check_new   = check_r | ({24'd0, b} << {pos_r[1:0], 3'b000});
  assign hdr_end     = {1'b0, HEADER_BYTES} + {1'b0, hdr_len_r};
  assign payload_end = hdr_end;
  assign is_payload  = (pos_r >= HEADER_BYTES) && ({1'b0, pos_r} < payload_end);
  assign frame_ends  = (pos_inc == body_len);
  assign size_done   = (pos_r[1:0] == 2'd3);
  assign crc_bad     = (check_new != (crc_r ^ ALL_ONES32));
  assign too_long    = (body_len < HEADER_BYTES) || (hdr_end > {1'b0, body_len});

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept && !halted_r && in_req.command == CMD_BYTE) begin
      case (phase_r)
        PH_SIZE: begin
          if (size_done && fs_new >= 32'd4) begin
            phase_nxt = (fs_new == 32'd4) ? PH_CRC : PH_BODY;
          end
        end
        PH_BODY: begin
          if (frame_ends) begin
            phase_nxt = PH_CRC;
          end
        end
        PH_CRC: begin
          if (pos_r[1:0] == 2'd3 && !crc_bad && !too_long) begin
            phase_nxt = PH_SIZE;
          end
        end
        default: phase_nxt = PH_SIZE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    pos_nxt        = pos_r;
    frame_size_nxt = frame_size_r;
    crc_nxt        = crc_r;
    check_nxt      = check_r;
    hdr_seq_nxt    = hdr_seq_r;
    hdr_ts_nxt     = hdr_ts_r;
    hdr_player_nxt = hdr_player_r;
    hdr_op_nxt     = hdr_op_r;
    hdr_len_nxt    = hdr_len_r;
    highest_nxt    = highest_r;
    count_nxt      = count_r;
    halted_nxt     = halted_r;
    res_valid      = 1'b0;
    res            = '0;
    res.next_sequence = highest_r + 64'd1;
    res.record_count  = count_r;

    if (accept && !halted_r) begin
      if (in_req.command == CMD_END) begin
        halted_nxt     = 1'b1;
        res_valid      = 1'b1;
        res.kind       = KIND_STOP;
        res.last       = 1'b1;
        res.stop_cause = (phase_r == PH_SIZE) ? CAUSE_CLEAN : CAUSE_TRUNCATED;
      end else begin
        case (phase_r)
          PH_SIZE: begin
            frame_size_nxt = fs_new;
            pos_nxt        = pos_inc;
            if (size_done) begin
              if (fs_new < 32'd4) begin
                halted_nxt     = 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_STOP;
                res.last       = 1'b1;
                res.stop_cause = CAUSE_SHORT;
              end else begin
                pos_nxt        = '0;
                crc_nxt        = ALL_ONES32;
                check_nxt      = '0;
                hdr_seq_nxt    = '0;
                hdr_ts_nxt     = '0;
                hdr_player_nxt = '0;
                hdr_op_nxt     = '0;
                hdr_len_nxt    = '0;
              end
            end
          end
          PH_BODY: begin
            crc_nxt = crc32_byte(crc_r, b);
            if (pos_r < 32'd8) begin
              hdr_seq_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
            end else if (pos_r < 32'd16) begin
              hdr_ts_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
            end else if (pos_r < 32'd24) begin
              hdr_player_nxt[{pos_r[2:0], 3'b000} +: 8] = b;
            end else if (pos_r == 32'd24) begin
              hdr_op_nxt = b;
            end else if (pos_r < HEADER_BYTES) begin
              hdr_len_nxt[{pos_r[1:0] - 2'd1, 3'b000} +: 8] = b;
            end
            pos_nxt = frame_ends ? 32'd0 : pos_inc;
            if (is_payload) begin
              res_valid        = 1'b1;
              res.kind         = KIND_PAYLOAD;
              res.payload_byte = b;
              res.sequence_res = hdr_seq_r;
              res.timestamp    = hdr_ts_r;
              res.player_id    = hdr_player_r;
              res.operation    = hdr_op_r;
              res.data_size    = hdr_len_r;
            end
          end
          PH_CRC: begin
            check_nxt = check_new;
            pos_nxt   = pos_inc;
            if (pos_r[1:0] == 2'd3) begin
              if (crc_bad || too_long) begin
                halted_nxt     = 1'b1;
                res_valid      = 1'b1;
                res.kind       = KIND_STOP;
                res.last       = 1'b1;
                res.stop_cause = crc_bad ? CAUSE_CRC : CAUSE_TOO_LONG;
              end else begin
                if (hdr_seq_r > highest_r) begin
                  highest_nxt = hdr_seq_r;
                end
                if (count_r != ALL_ONES32) begin
                  count_nxt = count_r + 32'd1;
                end
                res_valid         = 1'b1;
                res.kind          = KIND_RECORD;
                res.sequence_res  = hdr_seq_r;
                res.timestamp     = hdr_ts_r;
                res.player_id     = hdr_player_r;
                res.operation     = hdr_op_r;
                res.data_size     = hdr_len_r;
                res.next_sequence = highest_nxt + 64'd1;
                res.record_count  = count_nxt;
                pos_nxt           = '0;
                frame_size_nxt    = '0;
                check_nxt         = '0;
                crc_nxt           = ALL_ONES32;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SIZE;
      pos_r        <= '0;
      frame_size_r <= '0;
      crc_r        <= ALL_ONES32;
      check_r      <= '0;
      hdr_seq_r    <= '0;
      hdr_ts_r     <= '0;
      hdr_player_r <= '0;
      hdr_op_r     <= '0;
      hdr_len_r    <= '0;
      highest_r    <= '0;
      count_r      <= '0;
      halted_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      pos_r        <= pos_nxt;
      frame_size_r <= frame_size_nxt;
      crc_r        <= crc_nxt;
      check_r      <= check_nxt;
      hdr_seq_r    <= hdr_seq_nxt;
      hdr_ts_r     <= hdr_ts_nxt;
      hdr_player_r <= hdr_player_nxt;
      hdr_op_r     <= hdr_op_nxt;
      hdr_len_r    <= hdr_len_nxt;
      highest_r    <= highest_nxt;
      count_r      <= count_nxt;
      halted_r     <= halted_nxt;
    end
  end

  // result register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

endmodule

### verif/lrd_result_monitor.sv
// Result monitor for the log record deframer: predicts every result and compares it.
`timescale 1ns / 1ps

module lrd_result_monitor
  import lrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_req_t     in_req,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_res_t    out_res,
  output int          fail_count,
  output int          due_count,
  output int          record_total,
  output int          payload_total,
  output logic [2:0]  final_cause
);

  out_res_t    due_results[$];

  phase_t      ph;
  logic [31:0] pos;
  logic [31:0] fsize;
  logic [31:0] crc;
  logic [31:0] chk;
  logic [63:0] hseq;
  logic [63:0] hts;
  logic [63:0] hpid;
  logic [7:0]  hop;
  logic [31:0] hlen;
  logic [63:0] top_seq;
  logic [31:0] acc_cnt;
  logic        halted;

  // bit-serial reflected CRC-32
  function automatic logic [31:0] crc_shift(input logic [31:0] c, input logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      c = (c[0] ^ b[i]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void post_result(kind_t k, logic [7:0] pb, bit with_hdr, cause_t cz);
    out_res_t r;
    r.kind          = k;
    r.payload_byte  = pb;
    r.sequence_res  = with_hdr ? hseq : 64'd0;
    r.timestamp     = with_hdr ? hts : 64'd0;
    r.player_id     = with_hdr ? hpid : 64'd0;
    r.operation     = with_hdr ? hop : 8'd0;
    r.data_size     = with_hdr ? hlen : 32'd0;
    r.stop_cause    = cz;
    r.next_sequence = top_seq + 64'd1;
    r.record_count  = acc_cnt;
    r.last          = (k == KIND_STOP);
    if (k == KIND_PAYLOAD) payload_total++;
    if (k == KIND_RECORD) record_total++;
    due_results = {due_results, r};
  endfunction

  function automatic void close_log(cause_t cz);
    halted = 1'b1;
    final_cause = cz;
    post_result(KIND_STOP, 8'd0, 1'b0, cz);
  endfunction

  task automatic parse_log_byte(input in_req_t rq);
    logic [31:0] body_len;
    logic [31:0] p;
    logic [7:0]  b;
    logic        is_pay;
    if (halted) return;
    b = rq.data_byte;
    if (rq.command == CMD_END) begin
      close_log(ph == PH_SIZE ? CAUSE_CLEAN : CAUSE_TRUNCATED);
      return;
    end
    body_len = fsize - 32'd4;
    case (ph)
      PH_SIZE: begin
        fsize |= {24'd0, b} << {pos[1:0], 3'b000};
        pos++;
        if (pos >= 4) begin
          if (fsize < 4) begin
            close_log(CAUSE_SHORT);
          end else begin
            pos  = 0;
            crc  = ALL_ONES32;
            chk  = 0;
            hseq = 0;
            hts  = 0;
            hpid = 0;
            hop  = 0;
            hlen = 0;
            ph   = (fsize == 4) ? PH_CRC : PH_BODY;
          end
        end
      end
      PH_BODY: begin
        p = pos;
        crc = crc_shift(crc, b);
        if (p < 8) hseq[8 * p[2:0] +: 8] = b;
        else if (p < 16) hts[8 * p[2:0] +: 8] = b;
        else if (p < 24) hpid[8 * p[2:0] +: 8] = b;
        else if (p == 24) hop = b;
        else if (p < HEADER_BYTES) hlen[8 * (p - 25) +: 8] = b;
        is_pay = (p >= HEADER_BYTES) &&
                 ({1'b0, p} < {1'b0, HEADER_BYTES} + {1'b0, hlen});
        pos++;
        if (pos >= body_len) begin
          pos = 0;
          ph  = PH_CRC;
        end
        if (is_pay) post_result(KIND_PAYLOAD, b, 1'b1, CAUSE_CLEAN);
      end
      default: begin
        chk |= {24'd0, b} << {pos[1:0], 3'b000};
        pos++;
        if (pos >= 4) begin
          if (chk != ~crc) begin
            close_log(CAUSE_CRC);
          end else if (body_len < HEADER_BYTES ||
                       {1'b0, HEADER_BYTES} + {1'b0, hlen} > {1'b0, body_len}) begin
            close_log(CAUSE_TOO_LONG);
          end else begin
            if (hseq > top_seq) top_seq = hseq;
            if (acc_cnt != ALL_ONES32) acc_cnt++;
            post_result(KIND_RECORD, 8'd0, 1'b1, CAUSE_CLEAN);
            ph    = PH_SIZE;
            pos   = 0;
            fsize = 0;
            chk   = 0;
            crc   = ALL_ONES32;
          end
        end
      end
    endcase
  endtask

  function automatic void check_field(string fld, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_res_t want;
    if (!rst_n) begin
      ph            = PH_SIZE;
      pos           = 0;
      fsize         = 0;
      crc           = ALL_ONES32;
      chk           = 0;
      hseq          = 0;
      hts           = 0;
      hpid          = 0;
      hop           = 0;
      hlen          = 0;
      top_seq       = 0;
      acc_cnt       = 0;
      halted        = 1'b0;
      final_cause   = CAUSE_CLEAN;
      record_total  = 0;
      payload_total = 0;
      due_results.delete();
    end else begin
      if (in_valid && !in_stall) parse_log_byte(in_req);
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_res);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(out_res.kind));
          check_field("payload_byte", 64'(want.payload_byte), 64'(out_res.payload_byte));
          check_field("sequence_res", want.sequence_res, out_res.sequence_res);
          check_field("timestamp", want.timestamp, out_res.timestamp);
          check_field("player_id", want.player_id, out_res.player_id);
          check_field("operation", 64'(want.operation), 64'(out_res.operation));
          check_field("data_size", 64'(want.data_size), 64'(out_res.data_size));
          check_field("stop_cause", 64'(want.stop_cause), 64'(out_res.stop_cause));
          check_field("next_sequence", want.next_sequence, out_res.next_sequence);
          check_field("record_count", 64'(want.record_count), 64'(out_res.record_count));
          check_field("last", 64'(want.last), 64'(out_res.last));
        end
      end
    end
    due_count = due_results.size();
  end

endmodule

### verif/tb_top.sv
// Top of the log record deframer testbench: clock, reset, log stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import lrd_pkg::*;

  localparam int PHASE_LEN   = 600;
  localparam int LOG_ITEMS   = 1700;
  localparam int HOLD_AT     = 1250;
  localparam int HOLD_CYCLES = 60;
  localparam int QUIET_LIMIT = 3000;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_req_t    in_req;
  logic       out_valid;
  logic       out_stall;
  out_res_t   out_res;
  logic       hold_off;
  int         items_sent = 0;
  int         fail_count;
  int         due_count;
  int         record_total;
  int         payload_total;
  logic [2:0] final_cause;

  always #5 clk = ~clk;

  log_record_deframer_crc32_check_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  lrd_result_monitor res_mon (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .fail_count    (fail_count),
    .due_count     (due_count),
    .record_total  (record_total),
    .payload_total (payload_total),
    .final_cause   (final_cause)
  );

  always @(negedge clk) begin
    int pct;
    pct = (items_sent < PHASE_LEN) ? 49 : (items_sent < 2 * PHASE_LEN) ? 28 : 0;
    out_stall <= hold_off || ($urandom_range(0, 99) < pct);
  end

  // long receiver hold-off while requests keep coming
  initial begin
    hold_off = 1'b0;
    wait (items_sent >= HOLD_AT);
    @(negedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_req(input cmd_t c, input logic [7:0] b);
    int  pct;
    bit  done;
    pct = (items_sent < PHASE_LEN) ? 28 : (items_sent < 2 * PHASE_LEN) ? 49 : 0;
    while ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= {c, b};
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      done = !in_stall;
      if (done) items_sent++;
      @(negedge clk);
    end
  endtask

  // cut_at >= 0 replaces that frame byte with an end-of-log request
  task automatic send_frame(input logic [63:0] seq, input logic [63:0] ts,
                            input logic [63:0] pid, input logic [7:0] op,
                            input logic [31:0] dsize, input int body_len,
                            input logic [31:0] crc_flip, input int cut_at);
    logic [231:0] hdr;
    logic [7:0]   frame[$];
    logic [31:0]  crc;
    logic [31:0]  fsize;
    hdr   = {dsize, op, pid, ts, seq};
    fsize = body_len + 4;
    crc   = ALL_ONES32;
    for (int i = 0; i < 4; i++) frame = {frame, fsize[8 * i +: 8]};
    for (int i = 0; i < body_len; i++) begin
      logic [7:0] b;
      b = (i < HEADER_BYTES) ? hdr[8 * i +: 8] : 8'($urandom);
      crc = crc32_byte(crc, b);
      frame = {frame, b};
    end
    crc = ~crc ^ crc_flip;
    for (int i = 0; i < 4; i++) frame = {frame, crc[8 * i +: 8]};
    foreach (frame[i]) begin
      if (i == cut_at) begin
        push_req(CMD_END, 8'($urandom));
        return;
      end
      push_req(CMD_BYTE, frame[i]);
    end
  endtask

  initial begin
    logic [63:0] run_seq;
    logic [31:0] ds;
    logic [31:0] flip;
    int          trail;
    int          blen;
    int          scenario;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    send_frame(64'd0, 64'd0, 64'd0, 8'd0, 32'd0, 29, 32'd0, -1);
    send_frame(64'd7, '1, '1, 8'hFF, 32'd5, 37, 32'd0, -1);
    send_frame(64'd3, 64'd1, 64'd2, 8'h80, 32'd1, 30, 32'd0, -1);

    run_seq = 64'd8;
    while (items_sent < LOG_ITEMS) begin
      if ($urandom_range(0, 9) == 0) run_seq = {$urandom, $urandom} >> $urandom_range(1, 63);
      else run_seq = run_seq + $urandom_range(0, 2);
      ds    = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
      trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      send_frame(run_seq, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), ds,
                 29 + ds + trail, 32'd0, -1);
    end

    // highest sequence wraps next_sequence to zero
    send_frame('1, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 32'd2, 31,
               32'd0, -1);
    send_frame(64'd9, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom), 32'd0, 29,
               32'd0, -1);

    // one way to close the log per run
    scenario = $urandom_range(0, 8);
    blen     = $urandom_range(29, 40);
    flip     = 32'd1 << $urandom_range(0, 31);
    ds       = $urandom_range(0, blen - 29);
    case (scenario)
      0: begin
        repeat ($urandom_range(0, 3)) push_req(CMD_BYTE, 8'($urandom));
        push_req(CMD_END, 8'($urandom));
      end
      1: begin
        push_req(CMD_BYTE, 8'($urandom_range(0, 3)));
        repeat (3) push_req(CMD_BYTE, 8'd0);
      end
      2: send_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    8'($urandom), ds, blen, 32'd0, $urandom_range(4, blen + 3));
      3: send_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    8'($urandom), ds, blen, 32'd0, $urandom_range(blen + 4, blen + 7));
      4: send_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    8'($urandom), ds, blen, flip, -1);
      5, 6: begin
        ds = $urandom_range(0, 1) ? 32'hFFFF_FFFF : blen - 28 + $urandom_range(0, 20);
        send_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   8'($urandom), ds, blen, (scenario == 5) ? flip : 32'd0, -1);
      end
      7: send_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    8'($urandom), 32'($urandom), 0, $urandom_range(0, 1) ? flip : 32'd0, -1);
      default: send_frame({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                          8'($urandom), 32'($urandom), $urandom_range(1, 28), 32'd0, -1);
    endcase

    // everything after the stop is ignored
    repeat (24) push_req(cmd_t'($urandom_range(0, 1)), 8'($urandom));
    in_valid <= 1'b0;

    while (due_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d requests: %0d records accepted, %0d payload bytes,",
             items_sent, record_total, payload_total);
    $display("log closed with cause %0d; sender and receiver gaps, a %0d-cycle hold-off, no gaps",
             final_cause, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
